/* src/scfp_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_pkg: shared types and constants of the sampled complex factor product
// Field layouts, operation and register codes, and the command and status
// structs that join the controller to the datapath.
// ----------------------------------------------------------------------------
package scfp_pkg;

    localparam int MAX_RANK = 16;
    localparam int MAX_ROWS = 1024;
    localparam int MAX_COLS = 1024;

    localparam int LINE_W  = 10;
    localparam int KPOS_W  = 4;
    localparam int ADDR_W  = LINE_W + KPOS_W;
    localparam int LEFT_DEPTH  = MAX_RANK * MAX_ROWS;
    localparam int RIGHT_DEPTH = MAX_RANK * MAX_COLS;
    localparam int ENTRY_W = 16;
    localparam int WORD_W  = 2 * ENTRY_W;
    localparam int PROD_W  = 2 * ENTRY_W;
    localparam int ACC_W   = 40;
    localparam int RANK_W  = 5;
    localparam int DIM_W   = 11;

    localparam logic [RANK_W-1:0] RANK_RESET = RANK_W'(MAX_RANK);
    localparam logic [DIM_W-1:0]  ROWS_RESET = DIM_W'(MAX_ROWS);
    localparam logic [DIM_W-1:0]  COLS_RESET = DIM_W'(MAX_COLS);

    localparam logic [1:0] OP_LOAD_LEFT  = 2'd0;
    localparam logic [1:0] OP_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] OP_QUERY      = 2'd2;

    localparam logic [1:0] REG_RANK = 2'd0;
    localparam logic [1:0] REG_ROWS = 2'd1;
    localparam logic [1:0] REG_COLS = 2'd2;

    typedef struct packed {
        logic [1:0]                op;
        logic [LINE_W-1:0]         factor_line;
        logic [KPOS_W-1:0]         rank_pos;
        logic signed [ENTRY_W-1:0] entry_re;
        logic signed [ENTRY_W-1:0] entry_im;
        logic [LINE_W-1:0]         query_row;
        logic [LINE_W-1:0]         query_col;
    } t_in_item;

    typedef struct packed {
        logic signed [ACC_W-1:0] result_re;
        logic signed [ACC_W-1:0] result_im;
        logic                    index_error;
    } t_out_item;

    typedef struct packed {
        logic              wr_left;
        logic              wr_right;
        logic              capture;
        logic              rd_en;
        logic [KPOS_W-1:0] rd_k;
    } t_dp_cmd;

    typedef struct packed {
        logic              range_err;
        logic [RANK_W-1:0] nrank;
    } t_dp_status;

endpackage

/* src/scfp_ctrl.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_ctrl: controller of the sampled complex factor product
// Accepts commands, issues store writes and the rank sweep of a query, waits
// for the multiply-accumulate pipeline to drain and raises the result strobe.
// ----------------------------------------------------------------------------
module scfp_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [1:0]            i_op,
    input  scfp_pkg::t_dp_status  i_status,
    output scfp_pkg::t_dp_cmd     o_cmd,
    output logic                  o_busy,
    output logic                  o_strobe
);

    localparam logic [1:0] S_IDLE  = 2'd0;
    localparam logic [1:0] S_RUN   = 2'd1;
    localparam logic [1:0] S_DRAIN = 2'd2;
    localparam logic [1:0] S_OUT   = 2'd3;

    logic [1:0]                    r_state, n_state;
    logic [scfp_pkg::KPOS_W-1:0]   r_k, n_k;
    logic                          r_drain, n_drain;
    logic                          accept;
    logic                          last_k;

    assign accept = i_start && (r_state == S_IDLE);
    assign last_k = ({1'b0, r_k} == (i_status.nrank - scfp_pkg::RANK_W'(1)));

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_drain = r_drain;
        o_cmd   = '0;
        o_cmd.rd_k = r_k;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_op)
                        scfp_pkg::OP_LOAD_LEFT:  o_cmd.wr_left  = 1'b1;
                        scfp_pkg::OP_LOAD_RIGHT: o_cmd.wr_right = 1'b1;
                        scfp_pkg::OP_QUERY: begin
                            o_cmd.capture = 1'b1;
                            n_k = '0;
                            // Out-of-range queries and an empty rank sum go
                            // straight to the result with cleared sums.
                            if (i_status.range_err || (i_status.nrank == '0)) begin
                                n_state = S_OUT;
                            end else begin
                                n_state = S_RUN;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_RUN: begin
                o_cmd.rd_en = 1'b1;
                n_k = r_k + scfp_pkg::KPOS_W'(1);
                if (last_k) begin
                    n_state = S_DRAIN;
                    n_drain = 1'b0;
                end
            end
            S_DRAIN: begin
                // Drains the pipeline: read data to products, products to sums.
                n_drain = 1'b1;
                if (r_drain) begin
                    n_state = S_OUT;
                end
            end
            S_OUT: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_drain <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_drain <= n_drain;
        end
    end

    assign o_busy   = (r_state != S_IDLE);
    assign o_strobe = (r_state == S_OUT);

endmodule

/* src/scfp_datapath.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// scfp_datapath: factor stores and complex multiply-accumulate
// Holds the configuration registers, both factor memories, the registered
// partial products and the two 40-bit accumulators that form the result.
// ----------------------------------------------------------------------------
module scfp_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  scfp_pkg::t_in_item     i_item,
    input  scfp_pkg::t_dp_cmd      i_cmd,
    input  logic                   i_cfg_we,
    input  logic [1:0]             i_cfg_index,
    input  logic [scfp_pkg::DIM_W-1:0] i_cfg_data,
    output scfp_pkg::t_dp_status   o_status,
    output scfp_pkg::t_out_item    o_result
);

    logic [scfp_pkg::WORD_W-1:0] left_mem  [scfp_pkg::LEFT_DEPTH];
    logic [scfp_pkg::WORD_W-1:0] right_mem [scfp_pkg::RIGHT_DEPTH];

    logic [scfp_pkg::RANK_W-1:0] r_rank;
    logic [scfp_pkg::DIM_W-1:0]  r_rows;
    logic [scfp_pkg::DIM_W-1:0]  r_cols;

    logic [scfp_pkg::LINE_W-1:0] r_row;
    logic [scfp_pkg::LINE_W-1:0] r_col;
    logic                        r_err;

    logic [scfp_pkg::WORD_W-1:0] r_lq, r_rq;
    logic                        r_rd_vld, r_prod_vld;

    logic signed [scfp_pkg::PROD_W-1:0] r_p_rr, r_p_ii, r_p_ri, r_p_ir;
    logic [scfp_pkg::ACC_W-1:0]  r_acc_re, r_acc_im;
    logic [scfp_pkg::ACC_W-1:0]  n_acc_re, n_acc_im;

    logic [scfp_pkg::ADDR_W-1:0] wr_addr;
    logic [scfp_pkg::WORD_W-1:0] wr_word;
    logic signed [scfp_pkg::ENTRY_W-1:0] ar, ai, br, bi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rank <= scfp_pkg::RANK_RESET;
            r_rows <= scfp_pkg::ROWS_RESET;
            r_cols <= scfp_pkg::COLS_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                scfp_pkg::REG_RANK: r_rank <= i_cfg_data[scfp_pkg::RANK_W-1:0];
                scfp_pkg::REG_ROWS: r_rows <= i_cfg_data;
                scfp_pkg::REG_COLS: r_cols <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // Rows and columns above the maxima need no saturation here: a 10-bit
    // index is always below them, as it is below the maxima themselves.
    assign o_status.range_err = ({1'b0, i_item.query_row} >= r_rows) ||
                                ({1'b0, i_item.query_col} >= r_cols);
    assign o_status.nrank = (r_rank > scfp_pkg::RANK_RESET) ? scfp_pkg::RANK_RESET
                                                            : r_rank;

    assign wr_addr = {i_item.factor_line, i_item.rank_pos};
    assign wr_word = {i_item.entry_im, i_item.entry_re};

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_left) begin
            left_mem[wr_addr] <= wr_word;
        end
        if (i_cmd.rd_en) begin
            r_lq <= left_mem[{r_row, i_cmd.rd_k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_right) begin
            right_mem[wr_addr] <= wr_word;
        end
        if (i_cmd.rd_en) begin
            r_rq <= right_mem[{r_col, i_cmd.rd_k}];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_row <= i_item.query_row;
            r_col <= i_item.query_col;
            r_err <= o_status.range_err;
        end
    end

    assign ar = $signed(r_lq[scfp_pkg::ENTRY_W-1:0]);
    assign ai = $signed(r_lq[scfp_pkg::WORD_W-1:scfp_pkg::ENTRY_W]);
    assign br = $signed(r_rq[scfp_pkg::ENTRY_W-1:0]);
    assign bi = $signed(r_rq[scfp_pkg::WORD_W-1:scfp_pkg::ENTRY_W]);

    always_ff @(posedge i_clk) begin
        r_p_rr <= ar * br;
        r_p_ii <= ai * bi;
        r_p_ri <= ar * bi;
        r_p_ir <= ai * br;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rd_vld   <= 1'b0;
            r_prod_vld <= 1'b0;
        end else begin
            r_rd_vld   <= i_cmd.rd_en;
            r_prod_vld <= r_rd_vld;
        end
    end

    always_comb begin
        n_acc_re = r_acc_re
                 + {{(scfp_pkg::ACC_W-scfp_pkg::PROD_W){r_p_rr[scfp_pkg::PROD_W-1]}}, r_p_rr}
                 - {{(scfp_pkg::ACC_W-scfp_pkg::PROD_W){r_p_ii[scfp_pkg::PROD_W-1]}}, r_p_ii};
        n_acc_im = r_acc_im
                 + {{(scfp_pkg::ACC_W-scfp_pkg::PROD_W){r_p_ri[scfp_pkg::PROD_W-1]}}, r_p_ri}
                 + {{(scfp_pkg::ACC_W-scfp_pkg::PROD_W){r_p_ir[scfp_pkg::PROD_W-1]}}, r_p_ir};
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_acc_re <= '0;
            r_acc_im <= '0;
        end else if (r_prod_vld) begin
            r_acc_re <= n_acc_re;
            r_acc_im <= n_acc_im;
        end
    end

    assign o_result.result_re   = r_acc_re;
    assign o_result.result_im   = r_acc_im;
    assign o_result.index_error = r_err;

endmodule

/* src/sampled_complex_factor_product_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_complex_factor_product_unit: sampled complex factor product
// Loads two complex Q2.14 factor matrices entry by entry and answers queries
// with one complex entry of their product, accumulated in Q12.28.
// ----------------------------------------------------------------------------
//
// Channel      Ports                                   Transfer when
// command      i_start, o_busy, i_item                 i_start && !o_busy
// result       o_strobe, o_result                      o_strobe (one cycle)
// config       i_cfg_valid, o_cfg_ready, i_cfg_index,  i_cfg_valid && o_cfg_ready
//              i_cfg_data
//
// A load never raises busy. A query in range reads the stores once per rank
// term, then drains the multiply pipeline and raises the result strobe; an
// out-of-range query or a rank of zero goes straight to the result. The
// receiver cannot stall the result; reset returns the registers to their
// maxima and leaves the stores undefined until written.
module sampled_complex_factor_product_unit (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_start,
    output logic                       o_busy,
    input  scfp_pkg::t_in_item         i_item,
    output logic                       o_strobe,
    output scfp_pkg::t_out_item        o_result,
    input  logic                       i_cfg_valid,
    output logic                       o_cfg_ready,
    input  logic [1:0]                 i_cfg_index,
    input  logic [scfp_pkg::DIM_W-1:0] i_cfg_data
);

    scfp_pkg::t_dp_cmd    cmd;
    scfp_pkg::t_dp_status status;

    assign o_cfg_ready = 1'b1;

    scfp_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (i_start),
        .i_op     (i_item.op),
        .i_status (status),
        .o_cmd    (cmd),
        .o_busy   (o_busy),
        .o_strobe (o_strobe)
    );

    scfp_datapath u_datapath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_item      (i_item),
        .i_cmd       (cmd),
        .i_cfg_we    (i_cfg_valid && o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_status    (status),
        .o_result    (o_result)
    );

endmodule

/* tb/sv/sampled_complex_factor_product_unit_tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sampled_complex_factor_product_unit_tb: self-checking bench for the unit
// A short table of directed commands and register writes, then phases of
// random loads and queries under random settings. Every query result is
// checked against a directed value or a model of the factor stores and registers.
// ----------------------------------------------------------------------------
module sampled_complex_factor_product_unit_tb;

    localparam int CLK_PERIOD   = 20;
    localparam int RESET_CYCLES = 8;
    localparam int TOTAL_ITEMS  = 1850;
    localparam int DRAIN_CYCLES = scfp_pkg::MAX_RANK + 8;
    localparam int STALL_LIMIT  = 2000;
    localparam int POOL_SIZE    = 4;
    localparam int POOL_IDX_W   = $clog2(POOL_SIZE);

    localparam logic [1:0] OP_UNUSED  = 2'd3;
    localparam logic [1:0] REG_UNUSED = 2'd3;

    localparam scfp_pkg::t_out_item RANGE_ERROR = {40'd0, 40'd0, 1'b1};
    localparam scfp_pkg::t_out_item ZERO_SUM    = {40'd0, 40'd0, 1'b0};

    typedef struct {
        bit                         is_register;
        logic [1:0]                 reg_index;
        logic [scfp_pkg::DIM_W-1:0] reg_value;
        scfp_pkg::t_in_item         item;
        bit                         typed;
        scfp_pkg::t_out_item        want;
    } t_directed_step;

    logic                       i_clk;
    logic                       i_rst_n;
    logic                       i_start;
    logic                       o_busy;
    scfp_pkg::t_in_item         i_item;
    logic                       o_strobe;
    scfp_pkg::t_out_item        o_result;
    logic                       i_cfg_valid;
    logic                       o_cfg_ready;
    logic [1:0]                 i_cfg_index;
    logic [scfp_pkg::DIM_W-1:0] i_cfg_data;

    // Bench copy of the factor stores, with a record of which entries hold data.
    logic [scfp_pkg::WORD_W-1:0] left_entries  [0:scfp_pkg::LEFT_DEPTH-1];
    logic [scfp_pkg::WORD_W-1:0] right_entries [0:scfp_pkg::RIGHT_DEPTH-1];
    bit                          left_loaded   [0:scfp_pkg::LEFT_DEPTH-1];
    bit                          right_loaded  [0:scfp_pkg::RIGHT_DEPTH-1];
    int                          terms_in_use;
    int                          rows_limit;
    int                          cols_limit;

    scfp_pkg::t_out_item         awaited_entries[$];
    t_directed_step              directed_steps[$];
    int                          mismatch_count;
    int                          items_accepted;
    bit                          bursty;
    logic [scfp_pkg::LINE_W-1:0] pool_rows [POOL_SIZE];
    logic [scfp_pkg::LINE_W-1:0] pool_cols [POOL_SIZE];

    sampled_complex_factor_product_unit u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (i_start),
        .o_busy      (o_busy),
        .i_item      (i_item),
        .o_strobe    (o_strobe),
        .o_result    (o_result),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #(CLK_PERIOD / 2) i_clk = ~i_clk;
    end

    task automatic flag_mismatch(input string what);
        $display("%0t ns mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Out-of-range queries read nothing; otherwise the sum runs over the rank
    // terms in use, with every partial product exact before the 40-bit wrap.
    function automatic scfp_pkg::t_out_item product_entry(
            input logic [scfp_pkg::LINE_W-1:0] row,
            input logic [scfp_pkg::LINE_W-1:0] col);
        scfp_pkg::t_out_item         entry;
        longint                      sum_re;
        longint                      sum_im;
        longint                      ar, ai, br, bi;
        logic [scfp_pkg::WORD_W-1:0] lw;
        logic [scfp_pkg::WORD_W-1:0] rw;
        entry  = ZERO_SUM;
        sum_re = 0;
        sum_im = 0;
        if (row >= rows_limit || col >= cols_limit) begin
            return RANGE_ERROR;
        end
        for (int k = 0; k < terms_in_use; k++) begin
            lw = left_entries[{row, scfp_pkg::KPOS_W'(k)}];
            rw = right_entries[{col, scfp_pkg::KPOS_W'(k)}];
            ar = longint'($signed(lw[15:0]));
            ai = longint'($signed(lw[31:16]));
            br = longint'($signed(rw[15:0]));
            bi = longint'($signed(rw[31:16]));
            sum_re += ar * br - ai * bi;
            sum_im += ar * bi + ai * br;
        end
        entry.result_re = sum_re[scfp_pkg::ACC_W-1:0];
        entry.result_im = sum_im[scfp_pkg::ACC_W-1:0];
        return entry;
    endfunction

    function automatic logic signed [scfp_pkg::ENTRY_W-1:0] random_entry();
        case ($urandom_range(0, 7))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            default: return scfp_pkg::ENTRY_W'($urandom);
        endcase
    endfunction

    function automatic scfp_pkg::t_in_item random_fields();
        scfp_pkg::t_in_item it;
        it.op          = OP_UNUSED;
        it.factor_line = scfp_pkg::LINE_W'($urandom);
        it.rank_pos    = scfp_pkg::KPOS_W'($urandom);
        it.entry_re    = random_entry();
        it.entry_im    = random_entry();
        it.query_row   = scfp_pkg::LINE_W'($urandom);
        it.query_col   = scfp_pkg::LINE_W'($urandom);
        return it;
    endfunction

    function automatic logic [scfp_pkg::DIM_W-1:0] pick_register_value(
            input logic [1:0] idx);
        logic [scfp_pkg::DIM_W-1:0] v;
        if (idx == scfp_pkg::REG_RANK) begin
            case ($urandom_range(0, 9))
                0: v = 0;
                1: v = 1;
                2: v = 16;
                3: v = 31;
                4: v = scfp_pkg::DIM_W'($urandom_range(17, 30));
                default: v = scfp_pkg::DIM_W'($urandom_range(1, 16));
            endcase
            // Bits above the rank field must be ignored.
            if ($urandom_range(0, 3) == 0) begin
                v[scfp_pkg::DIM_W-1:scfp_pkg::RANK_W] =
                    (scfp_pkg::DIM_W - scfp_pkg::RANK_W)'($urandom);
            end
        end else begin
            case ($urandom_range(0, 11))
                0: v = 0;
                1: v = 1;
                2: v = 1024;
                3: v = 2047;
                4: v = scfp_pkg::DIM_W'($urandom_range(1025, 2046));
                5: v = scfp_pkg::DIM_W'($urandom_range(2, 16));
                default: v = scfp_pkg::DIM_W'($urandom_range(1, 1024));
            endcase
        end
        return v;
    endfunction

    function automatic logic [scfp_pkg::LINE_W-1:0] pick_line(input int limit);
        int top;
        top = (limit > 0) ? limit - 1 : scfp_pkg::MAX_ROWS - 1;
        case ($urandom_range(0, 5))
            0: return '0;
            1: return scfp_pkg::LINE_W'(top);
            2: return scfp_pkg::LINE_W'($urandom);
            default: return scfp_pkg::LINE_W'($urandom_range(0, top));
        endcase
    endfunction

    function automatic logic [POOL_IDX_W-1:0] pick_slot();
        return POOL_IDX_W'($urandom_range(0, POOL_SIZE - 1));
    endfunction

    function automatic t_directed_step load_step(input logic [1:0] op,
                                                 input int line, input int k,
                                                 input int re, input int im);
        t_directed_step s;
        s             = '{default: '0};
        s.item.op          = op;
        s.item.factor_line = scfp_pkg::LINE_W'(line);
        s.item.rank_pos    = scfp_pkg::KPOS_W'(k);
        s.item.entry_re    = scfp_pkg::ENTRY_W'(re);
        s.item.entry_im    = scfp_pkg::ENTRY_W'(im);
        return s;
    endfunction

    function automatic t_directed_step query_step(input int row, input int col,
                                                  input bit typed,
                                                  input scfp_pkg::t_out_item want);
        t_directed_step s;
        s                = '{default: '0};
        s.item.op        = scfp_pkg::OP_QUERY;
        s.item.query_row = scfp_pkg::LINE_W'(row);
        s.item.query_col = scfp_pkg::LINE_W'(col);
        s.typed          = typed;
        s.want           = want;
        return s;
    endfunction

    function automatic t_directed_step register_step(input logic [1:0] idx, input int value);
        t_directed_step s;
        s             = '{default: '0};
        s.is_register = 1'b1;
        s.reg_index   = idx;
        s.reg_value   = scfp_pkg::DIM_W'(value);
        return s;
    endfunction

    // Presents one command, holds it until the transfer and updates the model.
    // The start line is left high so that a following command can go back to back.
    task automatic send_item(input scfp_pkg::t_in_item it);
        int gap;
        gap = bursty ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_start <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_item  <= it;
        i_start <= 1'b1;
        do @(posedge i_clk); while (o_busy);
        case (it.op)
            scfp_pkg::OP_LOAD_LEFT: begin
                left_entries[{it.factor_line, it.rank_pos}] = {it.entry_im, it.entry_re};
                left_loaded[{it.factor_line, it.rank_pos}]  = 1'b1;
            end
            scfp_pkg::OP_LOAD_RIGHT: begin
                right_entries[{it.factor_line, it.rank_pos}] = {it.entry_im, it.entry_re};
                right_loaded[{it.factor_line, it.rank_pos}]  = 1'b1;
            end
            scfp_pkg::OP_QUERY:
                awaited_entries.push_back(product_entry(it.query_row, it.query_col));
            default: ;
        endcase
        if (it.op != OP_UNUSED) begin
            items_accepted++;
        end
    endtask

    // Waits until the unit has gone quiet; a load raises no result, so a fixed
    // pause covers any work still in flight behind the last result.
    task automatic wait_for_quiet();
        i_start <= 1'b0;
        while (awaited_entries.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_register(input logic [1:0] idx,
                                  input logic [scfp_pkg::DIM_W-1:0] value);
        wait_for_quiet();
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= value;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        case (idx)
            scfp_pkg::REG_RANK:
                terms_in_use = (value[scfp_pkg::RANK_W-1:0] > scfp_pkg::MAX_RANK) ?
                               scfp_pkg::MAX_RANK : int'(value[scfp_pkg::RANK_W-1:0]);
            scfp_pkg::REG_ROWS:
                rows_limit = (value > scfp_pkg::MAX_ROWS) ? scfp_pkg::MAX_ROWS : int'(value);
            scfp_pkg::REG_COLS:
                cols_limit = (value > scfp_pkg::MAX_COLS) ? scfp_pkg::MAX_COLS : int'(value);
            default: ;
        endcase
    endtask

    // Loads any missing factor entries that the query will read, then queries.
    task automatic issue_query(input logic [scfp_pkg::LINE_W-1:0] row,
                               input logic [scfp_pkg::LINE_W-1:0] col);
        scfp_pkg::t_in_item it;
        if (row < rows_limit && col < cols_limit) begin
            for (int k = 0; k < terms_in_use; k++) begin
                if (!left_loaded[{row, scfp_pkg::KPOS_W'(k)}]) begin
                    it             = random_fields();
                    it.op          = scfp_pkg::OP_LOAD_LEFT;
                    it.factor_line = row;
                    it.rank_pos    = scfp_pkg::KPOS_W'(k);
                    send_item(it);
                end
                if (!right_loaded[{col, scfp_pkg::KPOS_W'(k)}]) begin
                    it             = random_fields();
                    it.op          = scfp_pkg::OP_LOAD_RIGHT;
                    it.factor_line = col;
                    it.rank_pos    = scfp_pkg::KPOS_W'(k);
                    send_item(it);
                end
            end
        end
        it           = random_fields();
        it.op        = scfp_pkg::OP_QUERY;
        it.query_row = row;
        it.query_col = col;
        send_item(it);
    endtask

    always @(posedge i_clk) begin : check_results
        scfp_pkg::t_out_item want;
        if (i_rst_n && o_strobe) begin
            if (awaited_entries.size() == 0) begin
                flag_mismatch($sformatf("result %h with no query outstanding", o_result));
            end else begin
                want = awaited_entries.pop_front();
                if (o_result.result_re !== want.result_re) begin
                    flag_mismatch($sformatf("result_re %h, expected %h",
                                            o_result.result_re, want.result_re));
                end
                if (o_result.result_im !== want.result_im) begin
                    flag_mismatch($sformatf("result_im %h, expected %h",
                                            o_result.result_im, want.result_im));
                end
                if (o_result.index_error !== want.index_error) begin
                    flag_mismatch($sformatf("index_error %b, expected %b",
                                            o_result.index_error, want.index_error));
                end
            end
        end
    end

    initial begin : watchdog
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < STALL_LIMIT) begin
            @(posedge i_clk);
            if (!i_rst_n || (i_start && !o_busy) || o_strobe || (i_cfg_valid && o_cfg_ready)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("TEST FAILED");
        $finish;
    end

    initial begin : stimulus
        scfp_pkg::t_in_item          it;
        int                          steps;
        int                          sel;
        logic [scfp_pkg::LINE_W-1:0] qrow;
        logic [scfp_pkg::LINE_W-1:0] qcol;

        i_rst_n     <= 1'b0;
        i_start     <= 1'b0;
        i_item      <= '0;
        i_cfg_valid <= 1'b0;
        i_cfg_index <= '0;
        i_cfg_data  <= '0;
        mismatch_count = 0;
        items_accepted = 0;
        bursty         = 1'b0;
        terms_in_use   = scfp_pkg::MAX_RANK;
        rows_limit     = scfp_pkg::MAX_ROWS;
        cols_limit     = scfp_pkg::MAX_COLS;

        // Extreme entries first at rank one, where the products can be read off.
        directed_steps.push_back(register_step(scfp_pkg::REG_RANK, 1));
        directed_steps.push_back(load_step(scfp_pkg::OP_LOAD_LEFT, 0, 0, -32768, -32768));
        directed_steps.push_back(load_step(scfp_pkg::OP_LOAD_RIGHT, 0, 0, -32768, -32768));
        directed_steps.push_back(query_step(0, 0, 1'b1, {40'd0, 40'h00_8000_0000, 1'b0}));
        directed_steps.push_back(load_step(scfp_pkg::OP_LOAD_LEFT, 1023, 0, 32767, 32767));
        directed_steps.push_back(load_step(scfp_pkg::OP_LOAD_RIGHT, 1023, 0, 32767, -32768));
        directed_steps.push_back(query_step(1023, 1023, 1'b0, ZERO_SUM));
        directed_steps.push_back(query_step(0, 1023, 1'b0, ZERO_SUM));
        directed_steps.push_back(query_step(1023, 0, 1'b0, ZERO_SUM));
        directed_steps.push_back(load_step(OP_UNUSED, 1023, 15, -1, -1));
        // A rank of zero sums nothing, so any in-range query gives zeros.
        directed_steps.push_back(register_step(scfp_pkg::REG_RANK, 0));
        directed_steps.push_back(query_step(1023, 1023, 1'b1, ZERO_SUM));
        directed_steps.push_back(query_step(512, 7, 1'b1, ZERO_SUM));
        directed_steps.push_back(register_step(scfp_pkg::REG_ROWS, 1));
        directed_steps.push_back(query_step(1, 0, 1'b1, RANGE_ERROR));
        directed_steps.push_back(query_step(0, 0, 1'b1, ZERO_SUM));
        directed_steps.push_back(register_step(scfp_pkg::REG_ROWS, 2047));
        directed_steps.push_back(register_step(scfp_pkg::REG_COLS, 0));
        directed_steps.push_back(query_step(0, 0, 1'b1, RANGE_ERROR));
        directed_steps.push_back(register_step(scfp_pkg::REG_COLS, 1023));
        directed_steps.push_back(query_step(0, 1023, 1'b1, RANGE_ERROR));
        directed_steps.push_back(register_step(scfp_pkg::REG_COLS, 1024));
        directed_steps.push_back(register_step(REG_UNUSED, 11'h7FF));
        directed_steps.push_back(register_step(scfp_pkg::REG_RANK, 2));
        directed_steps.push_back(load_step(scfp_pkg::OP_LOAD_LEFT, 0, 1, 32767, -32768));
        directed_steps.push_back(load_step(scfp_pkg::OP_LOAD_RIGHT, 0, 1, -32768, 32767));
        directed_steps.push_back(query_step(0, 0, 1'b0, ZERO_SUM));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (directed_steps[i]) begin
            if (directed_steps[i].is_register) begin
                write_register(directed_steps[i].reg_index, directed_steps[i].reg_value);
            end else begin
                send_item(directed_steps[i].item);
                if (directed_steps[i].typed) begin
                    awaited_entries[awaited_entries.size() - 1] = directed_steps[i].want;
                end
            end
        end

        // Each phase picks fresh settings and a small set of rows and columns,
        // so that most queries land on lines whose entries are already loaded.
        while (items_accepted < TOTAL_ITEMS) begin
            write_register(scfp_pkg::REG_RANK, pick_register_value(scfp_pkg::REG_RANK));
            write_register(scfp_pkg::REG_ROWS, pick_register_value(scfp_pkg::REG_ROWS));
            write_register(scfp_pkg::REG_COLS, pick_register_value(scfp_pkg::REG_COLS));
            if ($urandom_range(0, 3) == 0) begin
                write_register(REG_UNUSED, scfp_pkg::DIM_W'($urandom));
            end
            foreach (pool_rows[p]) begin
                pool_rows[p] = pick_line(rows_limit);
                pool_cols[p] = pick_line(cols_limit);
            end
            bursty = ($urandom_range(0, 3) == 0);
            steps  = $urandom_range(60, 160);
            for (int s = 0; s < steps && items_accepted < TOTAL_ITEMS; s++) begin
                sel = $urandom_range(0, 99);
                it  = random_fields();
                if (sel < 40) begin
                    issue_query(pool_rows[pick_slot()], pool_cols[pick_slot()]);
                end else if (sel < 50) begin
                    qrow = scfp_pkg::LINE_W'($urandom);
                    qcol = scfp_pkg::LINE_W'($urandom);
                    // Filling a random line at a high rank costs too many loads.
                    if (qrow >= rows_limit || qcol >= cols_limit || terms_in_use <= 2) begin
                        issue_query(qrow, qcol);
                    end else begin
                        issue_query(pool_rows[pick_slot()], pool_cols[pick_slot()]);
                    end
                end else if (sel < 88) begin
                    it.op          = $urandom_range(0, 1) ? scfp_pkg::OP_LOAD_LEFT :
                                                            scfp_pkg::OP_LOAD_RIGHT;
                    it.factor_line = (it.op == scfp_pkg::OP_LOAD_LEFT) ?
                                     pool_rows[pick_slot()] :
                                     pool_cols[pick_slot()];
                    send_item(it);
                end else if (sel < 95) begin
                    it.op = $urandom_range(0, 1) ? scfp_pkg::OP_LOAD_LEFT :
                                                   scfp_pkg::OP_LOAD_RIGHT;
                    send_item(it);
                end else begin
                    send_item(it);
                end
            end
        end

        wait_for_quiet();
        if (mismatch_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
